// File: src/afb_pkg.sv
`default_nettype none

package afb_pkg;

    localparam int FACE_LOG2  = 9;
    localparam int FACE_SIZE  = 1 << FACE_LOG2;
    localparam int TABLE_N    = FACE_SIZE * FACE_SIZE;
    localparam int COORD_BITS = 12;
    localparam int TIDX_W     = 18;
    localparam int BANK_AW    = 2 * (FACE_LOG2 - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;
    localparam int PROD_W     = 32 + COORD_BITS + 1;
    localparam int POS_W      = 48;
    localparam int W_W        = 34;
    localparam int MP_W       = 42;

    localparam logic [1:0] OP_MASK  = 2'd0;
    localparam logic [1:0] OP_FACE  = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;

    localparam logic [2:0] REG_AX_PER_X  = 3'd0;
    localparam logic [2:0] REG_AX_PER_Y  = 3'd1;
    localparam logic [2:0] REG_AX_OFFSET = 3'd2;
    localparam logic [2:0] REG_AY_PER_X  = 3'd3;
    localparam logic [2:0] REG_AY_PER_Y  = 3'd4;
    localparam logic [2:0] REG_AY_OFFSET = 3'd5;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FACE_SIZE - 1) << 16;
    localparam logic [47:0]      THRESH    = 48'd255 << 32;
    localparam logic [24:0]      RECIP_255 = 25'd16843009;

    typedef struct packed {
        logic signed [31:0] ax_per_x;
        logic signed [31:0] ax_per_y;
        logic signed [31:0] ax_offset;
        logic signed [31:0] ay_per_x;
        logic signed [31:0] ay_per_y;
        logic signed [31:0] ay_offset;
    } afb_coef_t;

    typedef struct packed {
        logic vld;
        logic blend;
        logic in_range;
    } afb_ctl_t;

    typedef struct packed {
        afb_ctl_t                 ctl;
        logic                     wr_mask;
        logic                     wr_face;
        logic [FACE_LOG2-1:0]     ix;
        logic [FACE_LOG2-1:0]     iy;
        logic [15:0]              fx;
        logic [15:0]              fy;
        logic [FACE_LOG2-1:0]     wrow;
        logic [FACE_LOG2-1:0]     wcol;
        logic [7:0]               wmask;
        logic [23:0]              rgb;
    } afb_addr_t;

    typedef struct packed {
        afb_ctl_t        ctl;
        logic            ix0;
        logic            iy0;
        logic [15:0]     fx;
        logic [15:0]     fy;
        logic [23:0]     rgb;
        logic [3:0][7:0] mask;
        logic [3:0][23:0] face;
    } afb_tap_t;

endpackage

`default_nettype wire

// File: src/affine_bilinear_feather_blend_core.sv
// Inverse affine warp with bilinear feathered alpha blend.
// Input channel (s_*): one beat per item. Operation OP_MASK stores a mask
// weight and OP_FACE stores an RGB texel at s_table_index; these give no
// result. OP_BLEND maps (s_pixel_x, s_pixel_y) into the face square, samples
// mask and face bilinearly and returns one result beat on the m_* channel.
// Configuration channel (cfg_*): writes one of six Q16.16 coefficients; it is
// always ready and must be used only while the block is idle.
// Throughput is one item per cycle while the receiver does not stall. Each
// item passes through eleven register stages: three for the affine map, one
// for the four-bank table read, and seven for the weight, product, sum,
// reciprocal divide by 255 and blend arithmetic.
// Tables are held in four banks per store split by row and column parity,
// so the four neighbors of a sample are read in the same cycle.
// Reset clears all valid bits and restores the coefficients to identity;
// table contents are undefined until written.
// When the receiver stalls, the whole pipeline holds and s_ready falls until
// the waiting result beat is taken; nothing is lost or repeated.
`default_nettype none

module affine_bilinear_feather_blend_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [1:0]                      s_operation,
    input  wire logic [afb_pkg::TIDX_W-1:0]      s_table_index,
    input  wire logic [7:0]                      s_mask_value,
    input  wire logic [7:0]                      s_red,
    input  wire logic [7:0]                      s_green,
    input  wire logic [7:0]                      s_blue,
    input  wire logic [afb_pkg::COORD_BITS-1:0]  s_pixel_x,
    input  wire logic [afb_pkg::COORD_BITS-1:0]  s_pixel_y,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [7:0]                           m_out_red,
    output logic [7:0]                           m_out_green,
    output logic [7:0]                           m_out_blue,
    output logic                                 m_changed,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [2:0]                      cfg_index,
    input  wire logic [31:0]                     cfg_data
);
    import afb_pkg::*;

    afb_coef_t coef_reg;
    afb_addr_t addr;
    afb_tap_t  tap;
    logic      en;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.ax_per_x  <= 32'sd65536;
            coef_reg.ax_per_y  <= '0;
            coef_reg.ax_offset <= '0;
            coef_reg.ay_per_x  <= '0;
            coef_reg.ay_per_y  <= 32'sd65536;
            coef_reg.ay_offset <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_AX_PER_X:  coef_reg.ax_per_x  <= cfg_data;
                REG_AX_PER_Y:  coef_reg.ax_per_y  <= cfg_data;
                REG_AX_OFFSET: coef_reg.ax_offset <= cfg_data;
                REG_AY_PER_X:  coef_reg.ay_per_x  <= cfg_data;
                REG_AY_PER_Y:  coef_reg.ay_per_y  <= cfg_data;
                REG_AY_OFFSET: coef_reg.ay_offset <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    afb_affine u_affine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_valid && s_ready),
        .op      (s_operation),
        .tidx    (s_table_index),
        .mval    (s_mask_value),
        .rgb     ({s_red, s_green, s_blue}),
        .px_in   (s_pixel_x),
        .py_in   (s_pixel_y),
        .coef    (coef_reg),
        .addr_o  (addr)
    );

    afb_tables u_tables (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .addr_i  (addr),
        .tap_o   (tap)
    );

    afb_blend u_blend (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .tap_i       (tap),
        .out_valid   (m_valid),
        .out_red     (m_out_red),
        .out_green   (m_out_green),
        .out_blue    (m_out_blue),
        .out_changed (m_changed)
    );

    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input blocked without a stalled result");
    a_reset_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");
    a_rise_on_move: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(en))
        else $error("result appeared while pipeline held");

endmodule

`default_nettype wire

// File: src/afb_affine.sv
`default_nettype none

module afb_affine (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            en,
    input  wire logic                            in_vld,
    input  wire logic [1:0]                      op,
    input  wire logic [afb_pkg::TIDX_W-1:0]      tidx,
    input  wire logic [7:0]                      mval,
    input  wire logic [23:0]                     rgb,
    input  wire logic [afb_pkg::COORD_BITS-1:0]  px_in,
    input  wire logic [afb_pkg::COORD_BITS-1:0]  py_in,
    input  wire afb_pkg::afb_coef_t              coef,
    output afb_pkg::afb_addr_t                   addr_o
);
    import afb_pkg::*;

    logic                      s1_vld_reg, s2_vld_reg;
    logic [1:0]                s1_op_reg, s2_op_reg;
    logic [TIDX_W-1:0]         s1_tidx_reg, s2_tidx_reg;
    logic [7:0]                s1_mval_reg, s2_mval_reg;
    logic [23:0]               s1_rgb_reg, s2_rgb_reg;
    logic signed [PROD_W-1:0]  s1_xx_reg, s1_xy_reg, s1_yx_reg, s1_yy_reg;
    logic signed [PROD_W-1:0]  s1_xx_next, s1_xy_next, s1_yx_next, s1_yy_next;
    logic signed [POS_W-1:0]   s2_px_reg, s2_py_reg, s2_px_next, s2_py_next;
    logic signed [COORD_BITS:0] xs, ys;
    afb_addr_t                 s3_reg, s3_next;
    logic [31:0]               tidx32;
    logic                      in_tab;

    assign xs = signed'({1'b0, px_in});
    assign ys = signed'({1'b0, py_in});

    always_comb begin
        s1_xx_next = coef.ax_per_x * xs;
        s1_xy_next = coef.ax_per_y * ys;
        s1_yx_next = coef.ay_per_x * xs;
        s1_yy_next = coef.ay_per_y * ys;
    end

    always_comb begin
        s2_px_next = POS_W'(s1_xx_reg) + POS_W'(s1_xy_reg) + POS_W'(coef.ax_offset);
        s2_py_next = POS_W'(s1_yx_reg) + POS_W'(s1_yy_reg) + POS_W'(coef.ay_offset);
    end

    always_comb begin
        tidx32            = 32'(s2_tidx_reg);
        in_tab            = tidx32 < TABLE_N;
        s3_next.ctl.vld   = s2_vld_reg;
        s3_next.ctl.blend = s2_op_reg == OP_BLEND;
        s3_next.ctl.in_range = !s2_px_reg[POS_W-1] && !s2_py_reg[POS_W-1]
                             && (unsigned'(s2_px_reg) < POS_LIMIT)
                             && (unsigned'(s2_py_reg) < POS_LIMIT);
        s3_next.wr_mask   = (s2_op_reg == OP_MASK) && in_tab;
        s3_next.wr_face   = (s2_op_reg == OP_FACE) && in_tab;
        s3_next.ix        = s2_px_reg[16 +: FACE_LOG2];
        s3_next.iy        = s2_py_reg[16 +: FACE_LOG2];
        s3_next.fx        = s2_px_reg[15:0];
        s3_next.fy        = s2_py_reg[15:0];
        s3_next.wrow      = tidx32[2*FACE_LOG2-1:FACE_LOG2];
        s3_next.wcol      = tidx32[FACE_LOG2-1:0];
        s3_next.wmask     = s2_mval_reg;
        s3_next.rgb       = s2_rgb_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s3_reg.ctl.vld <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_reg     <= s3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_op_reg   <= op;
            s1_tidx_reg <= tidx;
            s1_mval_reg <= mval;
            s1_rgb_reg  <= rgb;
            s1_xx_reg   <= s1_xx_next;
            s1_xy_reg   <= s1_xy_next;
            s1_yx_reg   <= s1_yx_next;
            s1_yy_reg   <= s1_yy_next;
            s2_op_reg   <= s1_op_reg;
            s2_tidx_reg <= s1_tidx_reg;
            s2_mval_reg <= s1_mval_reg;
            s2_rgb_reg  <= s1_rgb_reg;
            s2_px_reg   <= s2_px_next;
            s2_py_reg   <= s2_py_next;
        end
    end

    assign addr_o = s3_reg;

endmodule

`default_nettype wire

// File: src/afb_tables.sv
`default_nettype none

module afb_tables (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire afb_pkg::afb_addr_t addr_i,
    output afb_pkg::afb_tap_t       tap_o
);
    import afb_pkg::*;

    logic [7:0]  mask_rd [4];
    logic [23:0] face_rd [4];
    afb_ctl_t    ctl_reg;
    logic        ix0_reg, iy0_reg;
    logic [15:0] fx_reg, fy_reg;
    logic [23:0] rgb_reg;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BY = 1'(b >> 1);
        localparam logic BX = 1'(b & 1);

        logic [7:0]           mask_mem [BANK_DEPTH];
        logic [23:0]          face_mem [BANK_DEPTH];
        logic [FACE_LOG2-1:0] row, col;
        logic [BANK_AW-1:0]   raddr, waddr;
        logic                 wsel;
        logic [7:0]           mrd_reg;
        logic [23:0]          frd_reg;

        always_comb begin
            row   = addr_i.iy + FACE_LOG2'(addr_i.iy[0] ^ BY);
            col   = addr_i.ix + FACE_LOG2'(addr_i.ix[0] ^ BX);
            raddr = {row[FACE_LOG2-1:1], col[FACE_LOG2-1:1]};
            waddr = {addr_i.wrow[FACE_LOG2-1:1], addr_i.wcol[FACE_LOG2-1:1]};
            wsel  = addr_i.ctl.vld && (addr_i.wrow[0] == BY) && (addr_i.wcol[0] == BX);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (wsel && addr_i.wr_mask) begin
                    mask_mem[waddr] <= addr_i.wmask;
                end
                if (wsel && addr_i.wr_face) begin
                    face_mem[waddr] <= addr_i.rgb;
                end
                mrd_reg <= mask_mem[raddr];
                frd_reg <= face_mem[raddr];
            end
        end

        assign mask_rd[b] = mrd_reg;
        assign face_rd[b] = frd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.vld <= 1'b0;
        end else if (en) begin
            ctl_reg <= addr_i.ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ix0_reg <= addr_i.ix[0];
            iy0_reg <= addr_i.iy[0];
            fx_reg  <= addr_i.fx;
            fy_reg  <= addr_i.fy;
            rgb_reg <= addr_i.rgb;
        end
    end

    always_comb begin
        tap_o.ctl = ctl_reg;
        tap_o.ix0 = ix0_reg;
        tap_o.iy0 = iy0_reg;
        tap_o.fx  = fx_reg;
        tap_o.fy  = fy_reg;
        tap_o.rgb = rgb_reg;
        for (int k = 0; k < 4; k++) begin
            tap_o.mask[k] = mask_rd[k];
            tap_o.face[k] = face_rd[k];
        end
    end

endmodule

`default_nettype wire

// File: src/afb_blend.sv
`default_nettype none

module afb_blend (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire afb_pkg::afb_tap_t tap_i,
    output logic                   out_valid,
    output logic [7:0]             out_red,
    output logic [7:0]             out_green,
    output logic [7:0]             out_blue,
    output logic                   out_changed
);
    import afb_pkg::*;

    afb_ctl_t          s5_ctl_reg, s6_ctl_reg, s7_ctl_reg, s8_ctl_reg, s9_ctl_reg, s10_ctl_reg;
    logic [7:0]        s5_orig_reg [3], s6_orig_reg [3], s7_orig_reg [3];
    logic [7:0]        s8_orig_reg [3], s9_orig_reg [3], s10_orig_reg [3];
    logic [7:0]        s5_m_reg [4];
    logic [7:0]        s5_f_reg [3][4];
    logic [W_W-1:0]    s5_w_reg [4];
    logic [7:0]        s5_m_next [4];
    logic [7:0]        s5_f_next [3][4];
    logic [W_W-1:0]    s5_w_next [4];
    logic [16:0]       gx, gy, fx17, fy17;
    logic [1:0]        sw;
    logic [MP_W-1:0]   s6_mp_reg [4];
    logic [MP_W-1:0]   s6_fp_reg [3][4];
    logic [MP_W-1:0]   s7_msum_reg, s7_msum_next;
    logic [MP_W-1:0]   fsum [3];
    logic [23:0]       s7_f16_reg [3], s8_f16_reg [3], s9_f16_reg [3];
    logic              s8_thr_reg, s9_thr_reg, s10_thr_reg;
    logic [23:0]       s8_t_reg;
    logic [16:0]       s8_q_reg, s8_q_next;
    logic [48:0]       qprod;
    logic [16:0]       s9_a_reg, s9_a_next;
    logic [25:0]       rem;
    logic [16:0]       inv_a;
    logic [24:0]       s10_p1_reg [3];
    logic [40:0]       s10_p2_reg [3];
    logic [41:0]       acc [3];
    logic [7:0]        res [3];
    logic              out_valid_reg;
    logic [7:0]        out_rgb_reg [3];
    logic              out_changed_reg;
    logic              do_blend;

    always_comb begin
        sw   = {tap_i.iy0, tap_i.ix0};
        fx17 = {1'b0, tap_i.fx};
        fy17 = {1'b0, tap_i.fy};
        gx   = 17'h10000 - fx17;
        gy   = 17'h10000 - fy17;
        s5_w_next[0] = W_W'(gx) * W_W'(gy);
        s5_w_next[1] = W_W'(fx17) * W_W'(gy);
        s5_w_next[2] = W_W'(gx) * W_W'(fy17);
        s5_w_next[3] = W_W'(fx17) * W_W'(fy17);
        for (int k = 0; k < 4; k++) begin
            s5_m_next[k]    = tap_i.mask[2'(k) ^ sw];
            s5_f_next[0][k] = tap_i.face[2'(k) ^ sw][23:16];
            s5_f_next[1][k] = tap_i.face[2'(k) ^ sw][15:8];
            s5_f_next[2][k] = tap_i.face[2'(k) ^ sw][7:0];
        end
    end

    always_comb begin
        s7_msum_next = '0;
        for (int c = 0; c < 3; c++) begin
            fsum[c] = '0;
        end
        for (int k = 0; k < 4; k++) begin
            s7_msum_next = s7_msum_next + s6_mp_reg[k];
            for (int c = 0; c < 3; c++) begin
                fsum[c] = fsum[c] + s6_fp_reg[c][k];
            end
        end
    end

    always_comb begin
        qprod     = 49'(s7_msum_reg[39:16]) * 49'(RECIP_255);
        s8_q_next = qprod[48:32];
        rem       = 26'(s8_t_reg) - ((26'(s8_q_reg) << 8) - 26'(s8_q_reg));
        s9_a_next = (rem >= 26'd255) ? s8_q_reg + 17'd1 : s8_q_reg;
        inv_a     = 17'h10000 - s9_a_reg;
        do_blend  = s10_thr_reg && s10_ctl_reg.in_range;
        for (int c = 0; c < 3; c++) begin
            acc[c] = (42'(s10_p1_reg[c]) << 16) + 42'(s10_p2_reg[c]);
            res[c] = (acc[c][41:32] > 10'd255) ? 8'd255 : acc[c][39:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_ctl_reg.vld  <= 1'b0;
            s6_ctl_reg.vld  <= 1'b0;
            s7_ctl_reg.vld  <= 1'b0;
            s8_ctl_reg.vld  <= 1'b0;
            s9_ctl_reg.vld  <= 1'b0;
            s10_ctl_reg.vld <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else if (en) begin
            s5_ctl_reg    <= tap_i.ctl;
            s6_ctl_reg    <= s5_ctl_reg;
            s7_ctl_reg    <= s6_ctl_reg;
            s8_ctl_reg    <= s7_ctl_reg;
            s9_ctl_reg    <= s8_ctl_reg;
            s10_ctl_reg   <= s9_ctl_reg;
            out_valid_reg <= s10_ctl_reg.vld && s10_ctl_reg.blend;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_orig_reg[0] <= tap_i.rgb[23:16];
            s5_orig_reg[1] <= tap_i.rgb[15:8];
            s5_orig_reg[2] <= tap_i.rgb[7:0];
            for (int k = 0; k < 4; k++) begin
                s5_m_reg[k] <= s5_m_next[k];
                s5_w_reg[k] <= s5_w_next[k];
                s6_mp_reg[k] <= MP_W'(s5_m_reg[k]) * MP_W'(s5_w_reg[k]);
                for (int c = 0; c < 3; c++) begin
                    s5_f_reg[c][k]  <= s5_f_next[c][k];
                    s6_fp_reg[c][k] <= MP_W'(s5_f_reg[c][k]) * MP_W'(s5_w_reg[k]);
                end
            end
            s7_msum_reg <= s7_msum_next;
            s8_thr_reg  <= (48'(s7_msum_reg) * 48'd100) > THRESH;
            s8_t_reg    <= s7_msum_reg[39:16];
            s8_q_reg    <= s8_q_next;
            s9_thr_reg  <= s8_thr_reg;
            s9_a_reg    <= s9_a_next;
            s10_thr_reg <= s9_thr_reg;
            for (int c = 0; c < 3; c++) begin
                s6_orig_reg[c]  <= s5_orig_reg[c];
                s7_orig_reg[c]  <= s6_orig_reg[c];
                s8_orig_reg[c]  <= s7_orig_reg[c];
                s9_orig_reg[c]  <= s8_orig_reg[c];
                s10_orig_reg[c] <= s9_orig_reg[c];
                s7_f16_reg[c]   <= fsum[c][39:16];
                s8_f16_reg[c]   <= s7_f16_reg[c];
                s9_f16_reg[c]   <= s8_f16_reg[c];
                s10_p1_reg[c]   <= 25'(s9_orig_reg[c]) * 25'(inv_a);
                s10_p2_reg[c]   <= 41'(s9_f16_reg[c]) * 41'(s9_a_reg);
                out_rgb_reg[c]  <= do_blend ? res[c] : s10_orig_reg[c];
            end
            out_changed_reg <= do_blend;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_red     = out_rgb_reg[0];
    assign out_green   = out_rgb_reg[1];
    assign out_blue    = out_rgb_reg[2];
    assign out_changed = out_changed_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(s9_a_reg) && $stable(s10_ctl_reg))
        else $error("pipeline moved while stalled");
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s9_ctl_reg.vld && s9_ctl_reg.blend && s9_thr_reg |-> s9_a_reg <= 17'h10000)
        else $error("alpha out of range");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        en && s10_ctl_reg.vld && s10_ctl_reg.blend |=> out_valid_reg)
        else $error("blend result lost");

endmodule

`default_nettype wire

// File: tb/tb_affine_bilinear_feather_blend_core.sv
`timescale 1ns / 100ps

module tb_affine_bilinear_feather_blend_core;
    import afb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       changed;
    } pixel_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_operation = OP_MASK;
    logic [TIDX_W-1:0] s_table_index = '0;
    logic [7:0] s_mask_value = '0;
    logic [7:0] s_red = '0;
    logic [7:0] s_green = '0;
    logic [7:0] s_blue = '0;
    logic [COORD_BITS-1:0] s_pixel_x = '0;
    logic [COORD_BITS-1:0] s_pixel_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_out_red;
    logic [7:0] m_out_green;
    logic [7:0] m_out_blue;
    logic m_changed;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = REG_AX_PER_X;
    logic [31:0] cfg_data = '0;

    affine_bilinear_feather_blend_core dut (.*);

    always #4 aclk = ~aclk;

    logic signed [31:0] coef [0:5];
    logic [7:0] mask_tbl [0:TABLE_N-1];
    logic [23:0] face_tbl [0:TABLE_N-1];
    bit mask_loaded [0:TABLE_N-1];
    bit face_loaded [0:TABLE_N-1];

    pixel_t expected_pixels[$];
    int errors = 0;
    int cycles = 0;
    int blends_sent = 0;
    int blends_changed = 0;
    int loads_sent = 0;
    int results_seen = 0;
    bit idle_on = 1'b1;
    int rx_hold = 0;

    function automatic bit warp_sample(input logic [11:0] x, input logic [11:0] y,
                                       input logic [23:0] orig, output pixel_t res);
        longint px, py, lim;
        longint unsigned fx, fy, gx, gy, msum, a16, fsum, f16, acc;
        longint unsigned w [0:3];
        int ix, iy, base, c;
        int tap [0:3];
        px = longint'(coef[REG_AX_PER_X]) * longint'(x) + longint'(coef[REG_AX_PER_Y])
             * longint'(y) + longint'(coef[REG_AX_OFFSET]);
        py = longint'(coef[REG_AY_PER_X]) * longint'(x) + longint'(coef[REG_AY_PER_Y])
             * longint'(y) + longint'(coef[REG_AY_OFFSET]);
        lim = longint'(FACE_SIZE - 1) * 65536;
        res = {orig, 1'b0};
        if (px < 0 || px >= lim || py < 0 || py >= lim) return 1'b1;
        ix = int'(px >>> 16);
        iy = int'(py >>> 16);
        fx = px & 16'hFFFF;
        fy = py & 16'hFFFF;
        gx = 65536 - fx;
        gy = 65536 - fy;
        w[0] = gx * gy;
        w[1] = fx * gy;
        w[2] = gx * fy;
        w[3] = fx * fy;
        base = iy * FACE_SIZE + ix;
        tap[0] = base;
        tap[1] = base + 1;
        tap[2] = base + FACE_SIZE;
        tap[3] = base + FACE_SIZE + 1;
        msum = 0;
        for (int k = 0; k < 4; k++) begin
            if (!mask_loaded[tap[k]] || !face_loaded[tap[k]]) return 1'b0;
            msum += longint'(mask_tbl[tap[k]]) * w[k];
        end
        if (msum * 100 > (64'd255 << 32)) begin
            a16 = (msum / 255) >> 16;
            res.changed = 1'b1;
            for (c = 0; c < 3; c++) begin
                fsum = 0;
                for (int k = 0; k < 4; k++)
                    fsum += longint'(face_tbl[tap[k]][23-8*c -: 8]) * w[k];
                f16 = fsum >> 16;
                acc = ((longint'(orig[23-8*c -: 8]) * (65536 - a16)) << 16) + f16 * a16;
                acc = acc >> 32;
                if (acc > 255) acc = 255;
                res[24-8*c -: 8] = acc[7:0];
            end
        end
        return 1'b1;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [17:0] idx,
                             input logic [7:0] mval, input logic [23:0] rgb,
                             input logic [11:0] x, input logic [11:0] y);
        int gap;
        pixel_t res;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_table_index <= idx;
        s_mask_value <= mval;
        {s_red, s_green, s_blue} <= rgb;
        s_pixel_x <= x;
        s_pixel_y <= y;
        do @(posedge aclk); while (!(s_valid && s_ready));
        case (op)
            OP_MASK: begin
                mask_tbl[idx] = mval;
                mask_loaded[idx] = 1'b1;
                loads_sent++;
            end
            OP_FACE: begin
                face_tbl[idx] = rgb;
                face_loaded[idx] = 1'b1;
                loads_sent++;
            end
            OP_BLEND: begin
                void'(warp_sample(x, y, rgb, res));
                expected_pixels.insert(expected_pixels.size(), res);
                blends_sent++;
                if (res.changed) blends_changed++;
            end
            default: ;
        endcase
    endtask

    task automatic settle;
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_coef(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        coef[idx] = val;
    endtask

    task automatic load_affine(input logic [31:0] axx, input logic [31:0] axy,
                               input logic [31:0] axo, input logic [31:0] ayx,
                               input logic [31:0] ayy, input logic [31:0] ayo);
        settle();
        write_coef(REG_AX_PER_X, axx);
        write_coef(REG_AX_PER_Y, axy);
        write_coef(REG_AX_OFFSET, axo);
        write_coef(REG_AY_PER_X, ayx);
        write_coef(REG_AY_PER_Y, ayy);
        write_coef(REG_AY_OFFSET, ayo);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] draw_weight;
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 4));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_load(input logic [1:0] op, input int idx);
        send_item(op, 18'(idx), draw_weight(), 24'($urandom), 12'($urandom), 12'($urandom));
    endtask

    task automatic test_table_fill;
        for (int r = 0; r < 10; r++)
            for (int c = 0; c < 10; c++) begin
                send_load(OP_MASK, r * FACE_SIZE + c);
                send_load(OP_FACE, r * FACE_SIZE + c);
                send_load(OP_MASK, (FACE_SIZE - 1 - r) * FACE_SIZE + FACE_SIZE - 1 - c);
                send_load(OP_FACE, (FACE_SIZE - 1 - r) * FACE_SIZE + FACE_SIZE - 1 - c);
            end
    endtask

    task automatic test_directed;
        int e;
        e = 2 * FACE_SIZE + 2;
        send_item(OP_MASK, 18'(e), 8'd2, 24'h0, 12'd0, 12'd0);
        send_item(OP_BLEND, 18'h3FFFF, 8'hFF, 24'h123456, 12'd2, 12'd2);
        send_item(OP_MASK, 18'(e), 8'd3, 24'hFFFFFF, 12'hFFF, 12'hFFF);
        send_item(OP_BLEND, 18'h0, 8'h0, 24'hFFFFFF, 12'd2, 12'd2);
        e = 3 * FACE_SIZE + 3;
        send_item(OP_MASK, 18'(e), 8'd255, 24'h0, 12'd0, 12'd0);
        send_item(OP_FACE, 18'(e), 8'd0, 24'h00FF80, 12'd0, 12'd0);
        send_item(OP_BLEND, 18'h0, 8'h0, 24'hFF00FF, 12'd3, 12'd3);
        send_item(OP_BLEND, 18'h0, 8'h0, 24'h000000, 12'd0, 12'd0);
        send_item(OP_BLEND, 18'h0, 8'h0, 24'hFFFFFF, 12'd510, 12'd510);
        send_item(OP_BLEND, 18'h0, 8'h0, 24'hA5A5A5, 12'd511, 12'd0);
        send_item(OP_BLEND, 18'h0, 8'h0, 24'h5A5A5A, 12'd0, 12'd511);
        send_item(OP_BLEND, 18'h3FFFF, 8'hFF, 24'h010203, 12'hFFF, 12'hFFF);
        send_item(OP_UNUSED, 18'h3FFFF, 8'hFF, 24'hFFFFFF, 12'hFFF, 12'hFFF);
        send_item(OP_BLEND, 18'h0, 8'h0, 24'h808080, 12'd8, 12'd7);
    endtask

    task automatic send_random_blend;
        logic [11:0] x, y;
        logic [23:0] rgb;
        pixel_t res;
        rgb = 24'($urandom);
        for (int t = 0; t < 40; t++) begin
            case ($urandom_range(0, 3))
                0: begin
                    x = 12'($urandom_range(0, 40));
                    y = 12'($urandom_range(0, 40));
                end
                1: begin
                    x = 12'($urandom_range(480, 520));
                    y = 12'($urandom_range(480, 520));
                end
                2: begin
                    x = 12'($urandom);
                    y = 12'($urandom);
                end
                default: begin
                    x = 12'($urandom_range(0, 15));
                    y = 12'($urandom_range(0, 15));
                end
            endcase
            if (warp_sample(x, y, rgb, res)) begin
                send_item(OP_BLEND, 18'($urandom), 8'($urandom), rgb, x, y);
                return;
            end
        end
        send_item(OP_UNUSED, 18'($urandom), 8'($urandom), rgb, 12'($urandom), 12'($urandom));
    endtask

    task automatic run_random_mix(input int count);
        int sel, r, c;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                send_random_blend();
            end else if (sel < 80) begin
                r = $urandom_range(0, 9);
                c = $urandom_range(0, 9);
                if ($urandom_range(0, 1)) begin
                    r = FACE_SIZE - 1 - r;
                    c = FACE_SIZE - 1 - c;
                end
                send_load(sel < 70 ? OP_MASK : OP_FACE, r * FACE_SIZE + c);
            end else if (sel < 92) begin
                send_load(sel < 86 ? OP_MASK : OP_FACE, int'($urandom_range(0, TABLE_N - 1)));
            end else begin
                send_item(OP_UNUSED, 18'($urandom), 8'($urandom), 24'($urandom),
                          12'($urandom), 12'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    task automatic test_identity;
        run_random_mix(120);
    endtask

    task automatic test_scaled_warp;
        load_affine(32'd16507, 32'd777, 32'h0000_1234, -32'sd500, 32'd16000, 32'h0003_8000);
        run_random_mix(140);
    endtask

    task automatic test_mirrored_warp;
        load_affine(-32'sd32768, 32'd300, 32'h01FE_7FFF, -32'sd211, -32'sd49152,
                    32'h01FE_C000);
        run_random_mix(140);
    endtask

    task automatic test_fixed_point;
        load_affine(32'd0, 32'd0, 32'h0007_ABCD, 32'd0, 32'd0, 32'h0004_0101);
        run_random_mix(80);
    endtask

    task automatic test_extreme_coefs;
        load_affine(32'h7FFF_FFFF, 32'h8000_0000, 32'h0005_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_random_mix(50);
        load_affine(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0000_0001, 32'hFFFF_FFFF);
        run_random_mix(50);
    endtask

    task automatic test_identity_restored;
        load_affine(32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0);
        run_random_mix(120);
    endtask

    always @(posedge aclk) begin
        pixel_t want, got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_pixels.size());
            $display("Verification failed");
            $finish;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_out_red, m_out_green, m_out_blue, m_changed};
                results_seen++;
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual %h",
                             $time, got);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (want.red !== got.red)
                        $display("%0t: red mismatch expected %h actual %h",
                                 $time, want.red, got.red);
                    if (want.green !== got.green)
                        $display("%0t: green mismatch expected %h actual %h",
                                 $time, want.green, got.green);
                    if (want.blue !== got.blue)
                        $display("%0t: blue mismatch expected %h actual %h",
                                 $time, want.blue, got.blue);
                    if (want.changed !== got.changed)
                        $display("%0t: changed mismatch expected %b actual %b",
                                 $time, want.changed, got.changed);
                    if (want !== got) errors++;
                end
                rx_hold = idle_on ? $urandom_range(0, 10) : 0;
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_ready <= (rx_hold == 0);
        end
    end

    initial begin
        for (int i = 0; i < 6; i++) coef[i] = '0;
        coef[REG_AX_PER_X] = 32'h0001_0000;
        coef[REG_AY_PER_Y] = 32'h0001_0000;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_table_fill();
        test_directed();
        test_identity();
        test_scaled_warp();
        test_mirrored_warp();
        test_fixed_point();
        test_extreme_coefs();
        test_identity_restored();
        settle();
        if (expected_pixels.size() != 0) errors++;
        $display("Covered %0d table loads and %0d blend pixels over six warp settings.",
                 loads_sent, blends_sent);
        $display("%0d pixels were blended, %0d passed through; %0d result beats checked.",
                 blends_changed, blends_sent - blends_changed, results_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: files.f
src/afb_pkg.sv
src/afb_affine.sv
src/afb_tables.sv
src/afb_blend.sv
src/affine_bilinear_feather_blend_core.sv
tb/tb_affine_bilinear_feather_blend_core.sv
